[hdl/rht_pkg.sv]
// Shared types and constants of the heard route table.
package rht_pkg;

  localparam int ROUTE_ENTRIES_DEF = 128;
  localparam int PORT_COUNT_DEF    = 16;

  localparam int CALL_W   = 56;
  localparam int PORT_W   = 4;
  localparam int TAG_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int COUNT_W  = 32;
  localparam int MODE_W   = 2;
  localparam int OPT_W    = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [2:0] {
    OP_LEARN, OP_LOOKUP, OP_ADD, OP_DELETE,
    OP_SET_PERM, OP_SET_IP, OP_GET_IP, OP_PORT_DOWN
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_NO_ROUTE, ST_FULL, ST_INVALID
  } status_t;

  localparam logic [OPT_W-1:0]  OPT_PERM_MAX    = 2'd1;
  localparam logic [OPT_W-1:0]  IP_MODE_INVALID = 2'd3;
  localparam logic [MODE_W-1:0] IP_MODE_DEFAULT = 2'd0;

  typedef struct packed {
    logic                valid;
    logic [CALL_W-1:0]   call;
    logic [PORT_W-1:0]   port;
    logic                has;
    logic [TAG_W-1:0]    tag;
    logic [STAMP_W-1:0]  stamp;
    logic [COUNT_W-1:0]  count;
    logic [MODE_W-1:0]   mode;
    logic                perm;
  } entry_t;

  typedef struct packed {
    op_t                 op;
    logic [CALL_W-1:0]   call;
    logic [PORT_W-1:0]   port;
    logic                has;
    logic [TAG_W-1:0]    tag;
    logic [OPT_W-1:0]    opt;
    logic [STAMP_W-1:0]  now;
    logic                bad;
  } cmd_t;

endpackage

[hdl/rht_if.sv]
// Handshake channels for request and result words.
interface rht_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  operation;
  logic [rht_pkg::CALL_W-1:0]  callsign;
  logic [rht_pkg::PORT_W-1:0]  port;
  logic [rht_pkg::TAG_W-1:0]   path_tag;
  logic                        has_path;
  logic [rht_pkg::OPT_W-1:0]   option_value;
  logic [rht_pkg::STAMP_W-1:0] now_seconds;
  modport source (output valid, operation, callsign, port, path_tag, has_path,
                  option_value, now_seconds, input ready);
  modport sink (input valid, operation, callsign, port, path_tag, has_path,
                option_value, now_seconds, output ready);
endinterface

interface rht_out_if;
  logic                          valid;
  logic                          ready;
  logic [rht_pkg::STATUS_W-1:0]  status;
  logic                          route_found;
  logic [rht_pkg::PORT_W-1:0]    route_port;
  logic [rht_pkg::TAG_W-1:0]     route_path_tag;
  logic                          route_has_path;
  logic [rht_pkg::MODE_W-1:0]    route_ip_mode;
  logic                          route_permanent;
  modport source (output valid, status, route_found, route_port, route_path_tag,
                  route_has_path, route_ip_mode, route_permanent, input ready);
  modport sink (input valid, status, route_found, route_port, route_path_tag,
                route_has_path, route_ip_mode, route_permanent, output ready);
endinterface

[hdl/rht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/rht_front.sv]
// Request intake: classify words and hold them in a two-deep queue.
module rht_front #(
  parameter int PORT_COUNT = rht_pkg::PORT_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rht_in_if.sink        in_ch,
  input  logic          clearing,
  output rht_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  rht_pkg::cmd_t q [2];
  rht_pkg::cmd_t cls;
  logic          wp, rp;
  logic [1:0]    cnt;
  logic          push, port_ok;

  assign in_ch.ready = (cnt != 2'd2) && !clearing;
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd         = q[rp];
  assign cmd_valid   = (cnt != 2'd0);

  always_comb begin
    port_ok  = {28'd0, in_ch.port} < 32'(PORT_COUNT);
    cls.op   = rht_pkg::op_t'(in_ch.operation);
    cls.call = in_ch.callsign;
    cls.port = in_ch.port;
    cls.has  = in_ch.has_path;
    cls.tag  = in_ch.has_path ? in_ch.path_tag : '0;
    cls.opt  = in_ch.option_value;
    cls.now  = in_ch.now_seconds;
    cls.bad  = (!port_ok && cls.op != rht_pkg::OP_LOOKUP && cls.op != rht_pkg::OP_GET_IP)
            || (cls.op == rht_pkg::OP_SET_PERM && cls.opt > rht_pkg::OPT_PERM_MAX)
            || (cls.op == rht_pkg::OP_SET_IP && cls.opt == rht_pkg::IP_MODE_INVALID);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (cmd_pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, cmd_pop};
    end
  end
endmodule

[hdl/rht_back.sv]
// Table engine: clear pass, per-word table scan, update and result register.
module rht_back #(
  parameter int ROUTE_ENTRIES = rht_pkg::ROUTE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  rht_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  output logic          clearing,
  rht_out_if.source     out_ch
);
  localparam int IDX_W = $clog2(ROUTE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int ENT_W = $bits(rht_pkg::entry_t);

  typedef enum logic [1:0] {CLEAR, IDLE, SCAN, FINISH} state_t;

  state_t          state;
  rht_pkg::cmd_t   cur;
  logic [CNT_W-1:0] cnt;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             hit_f, dflt_f, free_f, old_f;
  logic [IDX_W-1:0] hit_idx, free_idx, old_idx;
  rht_pkg::entry_t  hit_rec, dflt_rec;
  logic [rht_pkg::STAMP_W-1:0] old_stamp;

  logic             res_valid;
  rht_pkg::status_t res_status;
  logic             res_found;
  rht_pkg::entry_t  res_rec;

  logic [ENT_W-1:0] rdata, wdata;
  logic             we;
  logic [IDX_W-1:0] waddr;
  rht_pkg::entry_t  e, scan_w, fin_w, fin_rep;
  logic             m_c, m_cp, key_m, scan_we, fin_we, fin_found, fin_go;
  logic [IDX_W-1:0] fin_addr;
  rht_pkg::status_t fin_status;

  rht_ram #(.WIDTH(ENT_W), .DEPTH(ROUTE_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(cnt[IDX_W-1:0]), .rdata(rdata)
  );

  assign clearing = (state == CLEAR);
  assign cmd_pop  = (state == IDLE) && cmd_valid;
  assign fin_go   = (state == FINISH) && (!res_valid || out_ch.ready);

  assign out_ch.valid           = res_valid;
  assign out_ch.status          = res_status;
  assign out_ch.route_found     = res_found;
  assign out_ch.route_port      = res_rec.port;
  assign out_ch.route_path_tag  = res_rec.tag;
  assign out_ch.route_has_path  = res_rec.has;
  assign out_ch.route_ip_mode   = res_rec.mode;
  assign out_ch.route_permanent = res_rec.perm;

  always_comb begin
    e     = rht_pkg::entry_t'(rdata);
    m_c   = e.valid && e.call == cur.call;
    m_cp  = m_c && e.port == cur.port;
    key_m = (cur.op == rht_pkg::OP_LEARN || cur.op == rht_pkg::OP_LOOKUP) ? m_c : m_cp;
    scan_w  = e;
    scan_we = 1'b0;
    case (cur.op)
      rht_pkg::OP_DELETE: begin
        scan_we = m_cp;
        scan_w.valid = 1'b0;
      end
      rht_pkg::OP_SET_PERM: begin
        scan_we = m_cp;
        scan_w.perm  = cur.opt[0];
        scan_w.stamp = '0;
      end
      rht_pkg::OP_SET_IP: begin
        scan_we = m_cp;
        scan_w.mode = cur.opt;
      end
      rht_pkg::OP_PORT_DOWN: begin
        scan_we = e.valid && e.port == cur.port;
        scan_w.valid = 1'b0;
      end
      default: scan_we = 1'b0;
    endcase
  end

  always_comb begin
    fin_status = rht_pkg::ST_OK;
    fin_found  = 1'b0;
    fin_rep    = '0;
    fin_we     = 1'b0;
    fin_addr   = hit_idx;
    fin_w      = hit_rec;
    if (cur.bad) begin
      fin_status = rht_pkg::ST_INVALID;
    end else begin
      case (cur.op)
        rht_pkg::OP_LEARN: begin
          fin_we = 1'b1;
          if (hit_f) begin
            if (hit_rec.stamp != '0) fin_w.stamp = cur.now;
            if (hit_rec.perm) begin
              fin_w.count = hit_rec.count + 1'b1;
            end else begin
              fin_w.port = cur.port;
              fin_w.has  = cur.has;
              fin_w.tag  = cur.tag;
            end
          end else begin
            fin_w = '{valid: 1'b1, call: cur.call, port: cur.port, has: cur.has,
                      tag: cur.tag, stamp: cur.now, count: 32'd1,
                      mode: rht_pkg::IP_MODE_DEFAULT, perm: 1'b0};
            if (free_f) begin
              fin_addr = free_idx;
            end else if (old_f) begin
              fin_addr = old_idx;
            end else begin
              fin_we     = 1'b0;
              fin_status = rht_pkg::ST_FULL;
            end
          end
        end
        rht_pkg::OP_ADD: begin
          fin_we = 1'b1;
          if (hit_f) begin
            fin_w.has   = cur.has;
            fin_w.tag   = cur.tag;
            fin_w.stamp = '0;
          end else begin
            fin_w = '{valid: 1'b1, call: cur.call, port: cur.port, has: cur.has,
                      tag: cur.tag, stamp: '0, count: '0,
                      mode: rht_pkg::IP_MODE_DEFAULT, perm: 1'b0};
            fin_addr = free_idx;
            if (!free_f) begin
              fin_we     = 1'b0;
              fin_status = rht_pkg::ST_FULL;
            end
          end
        end
        rht_pkg::OP_LOOKUP: begin
          if (hit_f) begin
            fin_found = 1'b1;
            fin_rep   = hit_rec;
          end else if (dflt_f) begin
            fin_found = 1'b1;
            fin_rep   = dflt_rec;
          end else begin
            fin_status = rht_pkg::ST_NO_ROUTE;
          end
        end
        rht_pkg::OP_GET_IP: begin
          if (hit_f) begin
            fin_found = 1'b1;
            fin_rep   = hit_rec;
          end else begin
            fin_status = rht_pkg::ST_NO_ROUTE;
          end
        end
        default: fin_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = fin_addr;
    wdata = fin_w;
    case (state)
      CLEAR: begin
        we    = 1'b1;
        waddr = cnt[IDX_W-1:0];
        wdata = '0;
      end
      SCAN: begin
        we    = pend && scan_we;
        waddr = pend_idx;
        wdata = scan_w;
      end
      FINISH: we = fin_go && fin_we;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      cnt       <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && out_ch.ready && !fin_go) res_valid <= 1'b0;
      case (state)
        CLEAR: begin
          if (cnt == CNT_W'(ROUTE_ENTRIES - 1)) begin
            cnt   <= '0;
            state <= IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        IDLE: begin
          if (cmd_valid) begin
            cur    <= cmd;
            cnt    <= '0;
            pend   <= 1'b0;
            hit_f  <= 1'b0;
            dflt_f <= 1'b0;
            free_f <= 1'b0;
            old_f  <= 1'b0;
            state  <= cmd.bad ? FINISH : SCAN;
          end
        end
        SCAN: begin
          if (cnt != CNT_W'(ROUTE_ENTRIES)) begin
            cnt      <= cnt + 1'b1;
            pend     <= 1'b1;
            pend_idx <= cnt[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
            if (!pend) state <= FINISH;
          end
          if (pend) begin
            if (key_m && !hit_f) begin
              hit_f   <= 1'b1;
              hit_idx <= pend_idx;
              hit_rec <= e;
            end
            if (e.valid && e.call == '0 && !dflt_f) begin
              dflt_f   <= 1'b1;
              dflt_rec <= e;
            end
            if (!e.valid && !free_f) begin
              free_f   <= 1'b1;
              free_idx <= pend_idx;
            end
            if (e.valid && e.stamp != '0 && (!old_f || e.stamp < old_stamp)) begin
              old_f     <= 1'b1;
              old_idx   <= pend_idx;
              old_stamp <= e.stamp;
            end
          end
        end
        FINISH: begin
          if (fin_go) begin
            res_valid  <= 1'b1;
            res_status <= fin_status;
            res_found  <= fin_found;
            res_rec    <= fin_rep;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

[hdl/heard_route_table_top.sv]
// Top level of the heard route table.
//  channel  dir  payload
//  in_ch    in   operation, callsign, port, path_tag, has_path, option_value, now_seconds
//  out_ch   out  status, route_found, route_port, route_path_tag, route_has_path,
//                route_ip_mode, route_permanent
// Each word scans the whole table, one table RAM read per scan step. The engine takes a
// new word only once the last result is registered; invalid-argument words skip the scan.
// After reset a clear pass zeroes every table entry; in_ch.ready stays low meanwhile.
// A two-word queue and an output register let intake and results stall independently.
module heard_route_table_top #(
  parameter int ROUTE_ENTRIES = rht_pkg::ROUTE_ENTRIES_DEF,
  parameter int PORT_COUNT    = rht_pkg::PORT_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  rht_in_if.sink    in_ch,
  rht_out_if.source out_ch
);
  rht_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop, clearing;

  rht_front #(.PORT_COUNT(PORT_COUNT)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .clearing(clearing),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
  );

  rht_back #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_pop(cmd_pop), .clearing(clearing), .out_ch(out_ch)
  );
endmodule

[hdl/rht_chk.sv]
// Port-level checks of the heard route table, bound to the top level.
module rht_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rht_pkg::STATUS_W-1:0] status,
  input logic                         route_found,
  input logic [rht_pkg::MODE_W-1:0]   route_ip_mode
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during clear pass");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && route_found |-> status == rht_pkg::ST_OK)
    else $error("route reported with error status");

  a_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && !route_found |-> route_ip_mode == rht_pkg::IP_MODE_DEFAULT)
    else $error("ip mode set without route");
endmodule

bind heard_route_table_top rht_chk u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .status(out_ch.status), .route_found(out_ch.route_found),
  .route_ip_mode(out_ch.route_ip_mode)
);

[tb/sv/heard_route_table_top_tb.sv]
// Testbench of the heard route table: directed table, random traffic, predictor and checks.
module heard_route_table_top_tb;
  import rht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES   = ROUTE_ENTRIES_DEF;
  localparam int POOL      = 160;
  localparam int RAND_WORDS = 1280;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    op_t               op;
    logic [CALL_W-1:0] call;
    logic [PORT_W-1:0] port;
    logic [TAG_W-1:0]  tag;
    logic              has;
    logic [OPT_W-1:0]  opt;
    logic [STAMP_W-1:0] now;
    bit                typed;
    status_t           typed_st;
  } req_t;

  typedef struct {
    status_t           st;
    logic              found;
    logic [PORT_W-1:0] port;
    logic [TAG_W-1:0]  tag;
    logic              has;
    logic [MODE_W-1:0] mode;
    logic              perm;
  } route_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  rht_in_if  in_ch();
  rht_out_if out_ch();

  heard_route_table_top u_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bit                 tv[ENTRIES];
  logic [CALL_W-1:0]  tcall[ENTRIES];
  logic [PORT_W-1:0]  tport[ENTRIES];
  logic [TAG_W-1:0]   ttag[ENTRIES];
  logic               thas[ENTRIES];
  logic [STAMP_W-1:0] tstamp[ENTRIES];
  logic [COUNT_W-1:0] tcount[ENTRIES];
  logic [MODE_W-1:0]  tmode[ENTRIES];
  logic               tperm[ENTRIES];

  route_res_t route_q[$];
  int errors = 0;
  int idle_pct = 15;
  longint cycles = 0;
  logic [CALL_W-1:0] call_pool[POOL];
  logic [PORT_W-1:0] port_pool[POOL];
  logic [STAMP_W-1:0] clock_sec = 32'd1000;

  function automatic int find_slot(logic [CALL_W-1:0] c, logic [PORT_W-1:0] p, bit use_port);
    for (int i = 0; i < ENTRIES; i++)
      if (tv[i] && tcall[i] == c && (!use_port || tport[i] == p)) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < ENTRIES; i++)
      if (!tv[i]) return i;
    return -1;
  endfunction

  function automatic void fill_slot(int s, req_t w, logic [STAMP_W-1:0] stamp,
                                    logic [COUNT_W-1:0] cnt);
    tv[s] = 1'b1;
    tcall[s] = w.call;
    tport[s] = w.port;
    thas[s] = w.has;
    ttag[s] = w.has ? w.tag : '0;
    tstamp[s] = stamp;
    tcount[s] = cnt;
    tmode[s] = IP_MODE_DEFAULT;
    tperm[s] = 1'b0;
  endfunction

  function automatic route_res_t route_update(req_t w);
    route_res_t r;
    int s;
    r = '{ST_OK, 1'b0, '0, '0, 1'b0, '0, 1'b0};
    case (w.op)
      OP_LEARN: begin
        s = find_slot(w.call, w.port, 1'b0);
        if (s >= 0) begin
          if (tstamp[s] != 0) tstamp[s] = w.now;
          if (tperm[s]) tcount[s] = tcount[s] + 32'd1;
          else begin
            tport[s] = w.port;
            thas[s] = w.has;
            ttag[s] = w.has ? w.tag : '0;
          end
        end else begin
          s = find_free();
          if (s < 0)
            for (int i = 0; i < ENTRIES; i++)
              if (tstamp[i] != 0 && (s < 0 || tstamp[i] < tstamp[s])) s = i;
          if (s < 0) r.st = ST_FULL;
          else fill_slot(s, w, w.now, 32'd1);
        end
      end
      OP_LOOKUP, OP_GET_IP: begin
        s = find_slot(w.call, w.port, w.op == OP_GET_IP);
        if (s < 0 && w.op == OP_LOOKUP) s = find_slot('0, w.port, 1'b0);
        if (s < 0) r.st = ST_NO_ROUTE;
        else r = '{ST_OK, 1'b1, tport[s], ttag[s], thas[s], tmode[s], tperm[s]};
      end
      OP_ADD: begin
        s = find_slot(w.call, w.port, 1'b1);
        if (s >= 0) begin
          thas[s] = w.has;
          ttag[s] = w.has ? w.tag : '0;
          tstamp[s] = '0;
        end else begin
          s = find_free();
          if (s < 0) r.st = ST_FULL;
          else fill_slot(s, w, '0, '0);
        end
      end
      OP_SET_PERM, OP_SET_IP: begin
        if ((w.op == OP_SET_PERM && w.opt > OPT_PERM_MAX) ||
            (w.op == OP_SET_IP && w.opt == IP_MODE_INVALID)) r.st = ST_INVALID;
        else
          for (int i = 0; i < ENTRIES; i++)
            if (tv[i] && tcall[i] == w.call && tport[i] == w.port) begin
              if (w.op == OP_SET_PERM) begin
                tperm[i] = w.opt[0];
                tstamp[i] = '0;
              end else tmode[i] = w.opt;
            end
      end
      OP_DELETE:
        for (int i = 0; i < ENTRIES; i++)
          if (tv[i] && tcall[i] == w.call && tport[i] == w.port) tv[i] = 1'b0;
      default:
        for (int i = 0; i < ENTRIES; i++)
          if (tv[i] && tport[i] == w.port) tv[i] = 1'b0;
    endcase
    return r;
  endfunction

  function automatic req_t mk(op_t op, logic [CALL_W-1:0] call, logic [PORT_W-1:0] port,
                              logic [TAG_W-1:0] tag, logic has, logic [OPT_W-1:0] opt,
                              logic [STAMP_W-1:0] now, bit typed = 0,
                              status_t st = ST_OK);
    req_t w;
    w = '{op, call, port, tag, has, opt, now, typed, st};
    return w;
  endfunction

  function automatic req_t rand_req();
    req_t w;
    int k, sel;
    k = $urandom_range(POOL - 1);
    sel = $urandom_range(99);
    w = mk(OP_LEARN, call_pool[k], '0, 16'($urandom), 1'($urandom_range(1)),
           2'($urandom_range(3)), '0);
    w.port = ($urandom_range(99) < 70) ? port_pool[k] : 4'($urandom_range(15));
    if ($urandom_range(99) < 8) w.call = '0;
    else if ($urandom_range(99) < 8) w.call = 56'({$urandom, $urandom});
    if (sel < 40) w.op = OP_LEARN;
    else if (sel < 55) w.op = OP_LOOKUP;
    else if (sel < 65) w.op = OP_ADD;
    else if (sel < 71) w.op = OP_DELETE;
    else if (sel < 79) w.op = OP_SET_PERM;
    else if (sel < 87) w.op = OP_SET_IP;
    else if (sel < 99) w.op = OP_GET_IP;
    else w.op = OP_PORT_DOWN;
    if (w.op == OP_SET_PERM && $urandom_range(99) < 80) w.opt = 2'($urandom_range(1));
    clock_sec = clock_sec + $urandom_range(3);
    sel = $urandom_range(99);
    w.now = (sel < 2) ? '0 : (sel < 7) ? $urandom : clock_sec;
    return w;
  endfunction

  task automatic send_word(req_t w);
    route_res_t r;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = w.op;
    in_ch.callsign = w.call;
    in_ch.port = w.port;
    in_ch.path_tag = w.tag;
    in_ch.has_path = w.has;
    in_ch.option_value = w.opt;
    in_ch.now_seconds = w.now;
    do @(posedge clk); while (!in_ch.ready);
    r = route_update(w);
    if (w.typed) r = '{w.typed_st, 1'b0, '0, '0, 1'b0, '0, 1'b0};
    route_q.push_back(r);
  endtask

  always @(negedge clk)
    out_ch.ready <= (idle_pct == 0) || ($urandom_range(99) >= 15);

  always @(posedge clk) begin
    route_res_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (route_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = route_q.pop_front();
        if (out_ch.status != e.st) begin
          $error("status exp %0d got %0d", e.st, out_ch.status); errors++;
        end
        if (out_ch.route_found != e.found) begin
          $error("route_found exp %0d got %0d", e.found, out_ch.route_found); errors++;
        end
        if (out_ch.route_port != e.port) begin
          $error("route_port exp %0d got %0d", e.port, out_ch.route_port); errors++;
        end
        if (out_ch.route_path_tag != e.tag) begin
          $error("route_path_tag exp %h got %h", e.tag, out_ch.route_path_tag); errors++;
        end
        if (out_ch.route_has_path != e.has) begin
          $error("route_has_path exp %0d got %0d", e.has, out_ch.route_has_path); errors++;
        end
        if (out_ch.route_ip_mode != e.mode) begin
          $error("route_ip_mode exp %0d got %0d", e.mode, out_ch.route_ip_mode); errors++;
        end
        if (out_ch.route_permanent != e.perm) begin
          $error("route_permanent exp %0d got %0d", e.perm, out_ch.route_permanent);
          errors++;
        end
      end
    end
  end

  initial begin
    req_t plan[$];
    localparam logic [CALL_W-1:0] CMAX = '1;
    int waited;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_LEARN;
    in_ch.callsign = '0;
    in_ch.port = '0;
    in_ch.path_tag = '0;
    in_ch.has_path = 1'b0;
    in_ch.option_value = '0;
    in_ch.now_seconds = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < ENTRIES; i++) tv[i] = 1'b0;
    for (int i = 0; i < POOL; i++) begin
      call_pool[i] = 56'({$urandom, $urandom});
      port_pool[i] = 4'($urandom_range(15));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    plan.push_back(mk(OP_LOOKUP, 56'd5, 4'd0, '0, 0, 0, 1, 1, ST_NO_ROUTE));
    plan.push_back(mk(OP_GET_IP, 56'd5, 4'd0, '0, 0, 0, 1, 1, ST_NO_ROUTE));
    plan.push_back(mk(OP_SET_PERM, 56'd5, 4'd0, '0, 0, 2, 1, 1, ST_INVALID));
    plan.push_back(mk(OP_SET_IP, 56'd5, 4'd0, '0, 0, 3, 1, 1, ST_INVALID));
    plan.push_back(mk(OP_LEARN, CMAX, 4'd15, 16'hffff, 1, 3, 32'hffffffff, 1, ST_OK));
    plan.push_back(mk(OP_LOOKUP, CMAX, 4'd0, '0, 0, 0, 1));
    plan.push_back(mk(OP_LEARN, 56'd0, 4'd3, 16'h1234, 0, 0, 1));
    plan.push_back(mk(OP_LOOKUP, 56'd123, 4'd9, '0, 0, 0, 1));
    plan.push_back(mk(OP_ADD, CMAX, 4'd15, 16'h00ff, 0, 0, 2));
    plan.push_back(mk(OP_SET_PERM, CMAX, 4'd15, '0, 0, 1, 2));
    plan.push_back(mk(OP_LEARN, CMAX, 4'd1, 16'h5555, 1, 0, 3));
    plan.push_back(mk(OP_SET_IP, CMAX, 4'd15, '0, 0, 2, 3));
    plan.push_back(mk(OP_GET_IP, CMAX, 4'd15, '0, 0, 0, 3));
    plan.push_back(mk(OP_LEARN, 56'd77, 4'd6, 16'haaaa, 1, 0, 0));
    plan.push_back(mk(OP_LEARN, 56'd77, 4'd7, 16'h0001, 0, 0, 9));
    plan.push_back(mk(OP_LOOKUP, 56'd77, 4'd0, '0, 0, 0, 9));
    plan.push_back(mk(OP_DELETE, 56'd77, 4'd7, '0, 0, 0, 9));
    plan.push_back(mk(OP_DELETE, 56'd78, 4'd7, '0, 0, 0, 9));
    plan.push_back(mk(OP_SET_PERM, CMAX, 4'd15, '0, 0, 0, 9));
    plan.push_back(mk(OP_GET_IP, CMAX, 4'd15, '0, 0, 0, 9));
    plan.push_back(mk(OP_PORT_DOWN, '0, 4'd3, '0, 0, 0, 9));
    plan.push_back(mk(OP_LOOKUP, 56'd123, 4'd0, '0, 0, 0, 9));
    foreach (plan[i]) send_word(plan[i]);

    // fill the table with manual entries, then force drops
    for (int p = 0; p < 16; p++) send_word(mk(OP_PORT_DOWN, '0, 4'(p), '0, 0, 0, 9));
    for (int i = 0; i < ENTRIES; i++)
      send_word(mk(OP_ADD, call_pool[i], port_pool[i], 16'($urandom),
                   1'($urandom_range(1)), 0, 9));
    send_word(mk(OP_LEARN, 56'h42, 4'd2, '0, 0, 0, 50, 1, ST_FULL));
    send_word(mk(OP_ADD, 56'h42, 4'd2, '0, 0, 0, 50, 1, ST_FULL));

    for (int n = 0; n < RAND_WORDS; n++) begin
      idle_pct = (n >= 600 && n < 850) ? 0 : 15;
      send_word(rand_req());
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    waited = 0;
    while (route_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (ENTRIES + 20) @(posedge clk);
    if (errors == 0 && route_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
